FILE: design/ddct_pkg.sv
// Package for the dual down-counter timer: payload structs, register offsets,
// operation codes and control bit positions. No dependencies.
`timescale 1ns / 1ps

package ddct_pkg;

    // Width of each down-counter and of its reload register (16 to 32).
    localparam int CNT_W = 32;

    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt CNT_FULL_MASK  = '1;
    localparam t_cnt CNT_LOW16_MASK = t_cnt'(32'h0000_FFFF);

    // Operation codes of an input item. Code three does nothing.
    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;

    // Register offsets inside one counter's window (low three index bits).
    localparam logic [2:0] REG_LOAD    = 3'd0;
    localparam logic [2:0] REG_VALUE   = 3'd1;
    localparam logic [2:0] REG_CONTROL = 3'd2;
    localparam logic [2:0] REG_INTCLR  = 3'd3;
    localparam logic [2:0] REG_RIS     = 3'd4;
    localparam logic [2:0] REG_MIS     = 3'd5;
    localparam logic [2:0] REG_BGLOAD  = 3'd6;

    // Bit positions in the CONTROL register.
    localparam int CTL_ONESHOT_BIT  = 0;
    localparam int CTL_SIZE32_BIT   = 1;
    localparam int CTL_INTEN_BIT    = 5;
    localparam int CTL_PERIODIC_BIT = 6;
    localparam int CTL_ENABLE_BIT   = 7;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  reg_index;
        logic [31:0] write_data;
    } t_in_item;

    typedef struct packed {
        logic [31:0] read_data;
        logic        irq_first;
        logic        irq_second;
    } t_out_item;

endpackage

FILE: design/dual_down_counter_timer.sv
// Top level of the dual down-counter timer: input register, counter state and
// its update logic, result register. Depends on ddct_pkg.
`timescale 1ns / 1ps

// Two independent down-counters behind one sixteen-word register window, in
// the style of a common dual timer peripheral. Every input transfer carries
// one operation: a clock tick (both enabled counters step down), a register
// read or a register write; index bit 3 picks the second counter and the low
// three bits pick LOAD, VALUE, CONTROL, INTCLR, RIS, MIS or BGLOAD. Every
// input transfer produces exactly one output transfer holding the read data
// (zero for ticks, writes and unused offsets) and both masked interrupt lines
// as they stand after the operation. The block takes one transfer per clock
// and keeps that rate as long as the output side is ready; an item is held in
// the input register and then moves into the result register, which offers
// its result to the output side. The rate is set by the single state update
// per cycle: each counter's decrement, zero test and reload selection sit
// between the input register and the state registers. A stalled output holds
// the current result and the input register stays full, so at most two items
// are in flight.
module dual_down_counter_timer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  ddct_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output ddct_pkg::t_out_item o_out_data
);

    // Input register.
    logic               r_in_valid;
    ddct_pkg::t_in_item r_in;

    // Result register.
    logic                r_out_valid;
    ddct_pkg::t_out_item r_out;
    ddct_pkg::t_out_item n_out;

    // Counter state, one entry per counter.
    ddct_pkg::t_cnt r_count  [2];
    ddct_pkg::t_cnt r_reload [2];
    logic [7:0]     r_ctrl   [2];
    logic [1:0]     r_raw;
    logic [1:0]     r_halted;

    ddct_pkg::t_cnt n_count  [2];
    ddct_pkg::t_cnt n_reload [2];
    logic [7:0]     n_ctrl   [2];
    logic [1:0]     n_raw;
    logic [1:0]     n_halted;

    logic           fire;
    logic           sel_cnt;
    logic [2:0]     sel_reg;
    ddct_pkg::t_cnt wr_cnt;

    // The held item is processed when the result register is free or is
    // being emptied in this same cycle.
    assign fire       = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || fire;

    assign sel_cnt = r_in.reg_index[3];
    assign sel_reg = r_in.reg_index[2:0];
    assign wr_cnt  = r_in.write_data[ddct_pkg::CNT_W-1:0];

    // Next state of both counters. The loop covers the two independent
    // counters; ticks act on both, bus writes only on the selected one.
    always_comb begin
        ddct_pkg::t_cnt m;
        ddct_pkg::t_cnt v;
        ddct_pkg::t_cnt v_dec;
        for (int c = 0; c < 2; c++) begin
            n_count[c]  = r_count[c];
            n_reload[c] = r_reload[c];
            n_ctrl[c]   = r_ctrl[c];
            n_raw[c]    = r_raw[c];
            n_halted[c] = r_halted[c];

            // In 16-bit mode only the low half counts and is kept.
            m     = r_ctrl[c][ddct_pkg::CTL_SIZE32_BIT] ? ddct_pkg::CNT_FULL_MASK
                                                        : ddct_pkg::CNT_LOW16_MASK;
            v     = r_count[c] & m;
            v_dec = v - 1'b1;

            if (r_in.opcode == ddct_pkg::OP_TICK) begin
                if (r_ctrl[c][ddct_pkg::CTL_ENABLE_BIT] && !r_halted[c]) begin
                    if (v != '0) begin
                        n_count[c] = v_dec;
                        if (v_dec == '0) begin
                            n_raw[c] = 1'b1;
                            if (r_ctrl[c][ddct_pkg::CTL_ONESHOT_BIT]) begin
                                n_halted[c] = 1'b1;
                            end
                        end
                    end else if (r_ctrl[c][ddct_pkg::CTL_ONESHOT_BIT]) begin
                        // One-shot takes precedence over periodic.
                        n_count[c]  = v;
                        n_halted[c] = 1'b1;
                    end else if (r_ctrl[c][ddct_pkg::CTL_PERIODIC_BIT]) begin
                        n_count[c] = r_reload[c] & m;
                        if ((r_reload[c] & m) == '0) begin
                            n_raw[c] = 1'b1;
                        end
                    end else begin
                        // Free-running wraps to all ones at the current size.
                        n_count[c] = m;
                    end
                end
            end else if (r_in.opcode == ddct_pkg::OP_WRITE && sel_cnt == c[0]) begin
                unique case (sel_reg)
                    ddct_pkg::REG_LOAD: begin
                        n_reload[c] = wr_cnt;
                        n_count[c]  = wr_cnt;
                        n_halted[c] = 1'b0;
                        if ((wr_cnt & m) == '0) begin
                            n_raw[c] = 1'b1;
                        end
                    end
                    ddct_pkg::REG_CONTROL: begin
                        n_ctrl[c] = r_in.write_data[7:0];
                        if (!r_in.write_data[ddct_pkg::CTL_ONESHOT_BIT]) begin
                            n_halted[c] = 1'b0;
                        end
                    end
                    ddct_pkg::REG_INTCLR: begin
                        n_raw[c] = 1'b0;
                    end
                    ddct_pkg::REG_BGLOAD: begin
                        n_reload[c] = wr_cnt;
                    end
                    default: begin
                        // VALUE, RIS, MIS and the unused offset ignore writes.
                    end
                endcase
            end
        end
    end

    // Result of the held item. Reads never change state, so the read mux
    // looks at the current registers.
    always_comb begin
        ddct_pkg::t_cnt rm;
        rm = r_ctrl[sel_cnt][ddct_pkg::CTL_SIZE32_BIT] ? ddct_pkg::CNT_FULL_MASK
                                                      : ddct_pkg::CNT_LOW16_MASK;
        n_out.read_data = '0;
        if (r_in.opcode == ddct_pkg::OP_READ) begin
            unique case (sel_reg)
                ddct_pkg::REG_LOAD,
                ddct_pkg::REG_BGLOAD:  n_out.read_data = 32'(r_reload[sel_cnt]);
                ddct_pkg::REG_VALUE:   n_out.read_data = 32'(r_count[sel_cnt] & rm);
                ddct_pkg::REG_CONTROL: n_out.read_data = 32'(r_ctrl[sel_cnt]);
                ddct_pkg::REG_RIS:     n_out.read_data = 32'(r_raw[sel_cnt]);
                ddct_pkg::REG_MIS:     n_out.read_data =
                    32'(r_raw[sel_cnt] & r_ctrl[sel_cnt][ddct_pkg::CTL_INTEN_BIT]);
                default:               n_out.read_data = '0;
            endcase
        end
        // Interrupt lines reflect the state after this item.
        n_out.irq_first  = n_raw[0] & n_ctrl[0][ddct_pkg::CTL_INTEN_BIT];
        n_out.irq_second = n_raw[1] & n_ctrl[1][ddct_pkg::CTL_INTEN_BIT];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_raw       <= '0;
            r_halted    <= '0;
            for (int c = 0; c < 2; c++) begin
                r_count[c]  <= ddct_pkg::CNT_FULL_MASK;
                r_reload[c] <= '0;
                r_ctrl[c]   <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
                r_raw       <= n_raw;
                r_halted    <= n_halted;
                for (int c = 0; c < 2; c++) begin
                    r_count[c]  <= n_count[c];
                    r_reload[c] <= n_reload[c];
                    r_ctrl[c]   <= n_ctrl[c];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in_data;
        end
        if (fire) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: design/ddct_chk.sv
// Port-level checker for the dual down-counter timer, bound to the top level.
// Depends on ddct_pkg and dual_down_counter_timer.
`timescale 1ns / 1ps

module ddct_chk (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input ddct_pkg::t_out_item o_out_data
);

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // The input side only pushes back when a result is waiting and stalled.
    a_backpressure: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid && !i_out_ready)
        else $error("input stalled without an output stall");

    // Reset leaves both stages empty.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && o_in_ready)
        else $error("pipeline not empty after reset");

    // Both interrupt lines of a stalled result keep their levels until the
    // result is transferred.
    a_irq_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=>
            o_out_data.irq_first == $past(o_out_data.irq_first) &&
            o_out_data.irq_second == $past(o_out_data.irq_second))
        else $error("interrupt lines moved under a stalled result");

endmodule

bind dual_down_counter_timer ddct_chk u_ddct_chk (.*);
